// ===== rtl/lnpsg_pkg.sv =====
package lnpsg_pkg;

  // Ring depth and derived widths
  localparam int unsigned WINDOW_DEPTH = 32;
  localparam int unsigned AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CFG_W = 6;
  localparam int unsigned SUM_W = (CW > CFG_W + 1) ? CW : CFG_W + 1;

  // Field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 64;
  localparam int unsigned DATA_W = KEY_W + PAY_W;

  // Config bus
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes
  localparam logic [1:0] REG_KEEP_LEN  = 2'd0;
  localparam logic [1:0] REG_SKIP_LEN  = 2'd1;
  localparam logic [1:0] REG_KEYS_USED = 2'd2;

  // Item kinds
  localparam logic ACT_ROW   = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] keep_len;
    logic [CFG_W-1:0] skip_len;
    logic             keys_used;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_PUSH
  } state_e;

endpackage

// ===== rtl/lnpsg_ram.sv =====
module lnpsg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lnpsg_cfg.sv =====
module lnpsg_cfg
  import lnpsg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_KEEP_LEN:  cfg_d.keep_len  = pwdata[CFG_W-1:0];
        REG_SKIP_LEN:  cfg_d.skip_len  = pwdata[CFG_W-1:0];
        REG_KEYS_USED: cfg_d.keys_used = pwdata[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keep_len  <= CFG_W'(1);
      cfg_q.skip_len  <= '0;
      cfg_q.keys_used <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Readback
  always_comb begin
    unique case (paddr[3:2])
      REG_KEEP_LEN:  prdata = PDATA_W'(cfg_q.keep_len);
      REG_SKIP_LEN:  prdata = PDATA_W'(cfg_q.skip_len);
      REG_KEYS_USED: prdata = PDATA_W'(cfg_q.keys_used);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/last_n_per_sorted_group.sv =====
// Keeps the last keep-length rows of each group of a key-sorted stream,
// skipping the newest skip-count rows of the group.
// Input channel s_axis: tdata = {row_payload, row_key}, tuser = action
// (0 data row, 1 flush). Output channel m_axis: tdata = {out_payload,
// out_key}, tlast marks the last row emitted for one input item.
// Configuration goes through the APB port: keep length at 0x0,
// skip count at 0x4, keys_used at 0x8; write only while idle.
// A data row that closes no group is stored from the idle state. A row with a
// new key, or a flush, first drains the finished group from the ring RAM,
// oldest first, each emitted row through a RAM read state and an output load
// state, then a data row is stored in a push state. The first result takes
// the read and load states after the closing item into the output register.
// A stalled receiver holds the drain; the output register keeps its item
// while the next input item is taken.
// Reset empties the ring, forgets the current key and loads
// keep length 1, skip count 0, keys_used 1.
module last_n_per_sorted_group
  import lnpsg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,   // row_key[31:0], row_payload[95:32]
  input  logic               s_axis_tuser,   // action
  // result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DATA_W-1:0]  m_axis_tdata,   // out_key[31:0], out_payload[95:32]
  output logic               m_axis_tlast,   // out_last
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [KEY_W-1:0]  cur_key_q, cur_key_d;
  logic              have_key_q, have_key_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              last_q, last_d;
  logic              pend_q, pend_d;
  logic [KEY_W-1:0]  pend_key_q, pend_key_d;
  logic [PAY_W-1:0]  pend_pay_q, pend_pay_d;

  logic              ovalid_q, ovalid_d;
  logic [KEY_W-1:0]  okey_q;
  logic [PAY_W-1:0]  opay_q;
  logic              olast_q;
  logic              oload;

  logic              in_acc;
  logic [KEY_W-1:0]  in_key;
  logic [PAY_W-1:0]  in_pay;
  logic              close_now;
  logic [SUM_W-1:0]  off_x, cnt_x, keep_x, sum_x, size_x, inc_x, new_x, base_x;
  logic [CW-1:0]     keep;
  logic [CW-1:0]     start_x;
  logic [AW-1:0]     idx_inc;

  logic              push_en;
  logic [CW-1:0]     push_base;
  logic [PAY_W-1:0]  push_pay;
  logic              ram_we, ram_re;
  logic [PAY_W-1:0]  ram_rdata;

  lnpsg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lnpsg_ram #(
    .WIDTH (PAY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (push_pay),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_key        = s_axis_tdata[KEY_W-1:0];
  assign in_pay        = s_axis_tdata[DATA_W-1:KEY_W];

  // Group close decision and drain geometry
  assign close_now = (s_axis_tuser == ACT_FLUSH) ||
                     (cfg.keys_used && have_key_q && (in_key != cur_key_q));
  assign off_x  = SUM_W'(cfg.skip_len);
  assign cnt_x  = SUM_W'(count_q);
  assign keep_x = (off_x < cnt_x) ? (cnt_x - off_x) : '0;
  assign keep   = keep_x[CW-1:0];
  assign start_x = (CW'(head_q) >= count_q) ? (CW'(head_q) - count_q)
                                            : (CW'(head_q) + CW'(WINDOW_DEPTH) - count_q);
  assign idx_inc = (idx_q == AW'(WINDOW_DEPTH - 1)) ? '0 : idx_q + AW'(1);

  // Window size and count after a push
  assign sum_x  = SUM_W'(cfg.keep_len) + SUM_W'(cfg.skip_len);
  assign size_x = (sum_x > SUM_W'(WINDOW_DEPTH)) ? SUM_W'(WINDOW_DEPTH) : sum_x;
  assign base_x = SUM_W'(push_base);
  assign inc_x  = (base_x < SUM_W'(WINDOW_DEPTH)) ? base_x + SUM_W'(1) : base_x;
  assign new_x  = (inc_x > size_x) ? size_x : inc_x;
  assign ram_we = push_en && (size_x != '0);

  // Next state and datapath control
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    cur_key_d  = cur_key_q;
    have_key_d = have_key_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    last_d     = last_q;
    pend_d     = pend_q;
    pend_key_d = pend_key_q;
    pend_pay_d = pend_pay_q;
    push_en    = 1'b0;
    push_base  = count_q;
    push_pay   = in_pay;
    ram_re     = 1'b0;
    oload      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (close_now && (keep != '0)) begin
            // drain first, store a data row afterwards
            idx_d      = start_x[AW-1:0];
            rem_d      = keep;
            count_d    = '0;
            pend_d     = (s_axis_tuser == ACT_ROW);
            pend_key_d = in_key;
            pend_pay_d = in_pay;
            state_d    = ST_READ;
            if (s_axis_tuser == ACT_FLUSH) begin
              have_key_d = 1'b0;
            end
          end else if (s_axis_tuser == ACT_FLUSH) begin
            count_d    = '0;
            have_key_d = 1'b0;
          end else begin
            push_en    = 1'b1;
            push_base  = close_now ? '0 : count_q;
            cur_key_d  = in_key;
            have_key_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (!ovalid_q || m_axis_tready) begin
          ram_re  = 1'b1;
          idx_d   = idx_inc;
          rem_d   = rem_q - CW'(1);
          last_d  = (rem_q == CW'(1));
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        oload = 1'b1;
        if (rem_q != '0) begin
          state_d = ST_READ;
        end else if (pend_q) begin
          state_d = ST_PUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PUSH: begin
        push_en    = 1'b1;
        push_base  = count_q;
        push_pay   = pend_pay_q;
        cur_key_d  = pend_key_q;
        have_key_d = 1'b1;
        pend_d     = 1'b0;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (push_en) begin
      if (size_x == '0) begin
        count_d = '0;
      end else begin
        head_d  = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);
        count_d = new_x[CW-1:0];
      end
    end
  end

  // Output register handshake
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    if (oload) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      cur_key_q  <= '0;
      have_key_q <= 1'b0;
      idx_q      <= '0;
      rem_q      <= '0;
      last_q     <= 1'b0;
      pend_q     <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      cur_key_q  <= cur_key_d;
      have_key_q <= have_key_d;
      idx_q      <= idx_d;
      rem_q      <= rem_d;
      last_q     <= last_d;
      pend_q     <= pend_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_key_q <= pend_key_d;
    pend_pay_q <= pend_pay_d;
    if (oload) begin
      okey_q  <= cur_key_q;
      opay_q  <= ram_rdata;
      olast_q <= last_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {opay_q, okey_q};
  assign m_axis_tlast  = olast_q;

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lnpsg_pkg::*;

  // Register index past the register list; writes there must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             last;
  } kept_row_t;

  // Tracks the ring of newest rows per group and the kept rows still owed
  class tail_scoreboard;
    logic [PAY_W-1:0] ring[WINDOW_DEPTH];
    int unsigned      head;
    int unsigned      held;
    logic [KEY_W-1:0] group_key;
    bit               group_open;
    int unsigned      keep_len;
    int unsigned      skip_newest;
    bit               by_key;
    kept_row_t        owed_rows[$];
    int unsigned      errors;

    function new();
      head = 0;
      held = 0;
      group_key = '0;
      group_open = 0;
      keep_len = 1;
      skip_newest = 0;
      by_key = 1;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_KEEP_LEN:  keep_len = 32'(val[CFG_W-1:0]);
        REG_SKIP_LEN:  skip_newest = 32'(val[CFG_W-1:0]);
        REG_KEYS_USED: by_key = val[0];
        default: ;
      endcase
    endfunction

    // Drop the newest rows, then owe the rest oldest first
    function void close_group();
      int unsigned drop;
      int unsigned keep;
      int unsigned idx;
      kept_row_t   row;
      drop = (skip_newest < held) ? skip_newest : held;
      keep = held - drop;
      idx = (head + WINDOW_DEPTH - held) % WINDOW_DEPTH;
      for (int unsigned k = 0; k < keep; k++) begin
        row.key = group_key;
        row.payload = ring[idx[AW-1:0]];
        row.last = (k + 1 == keep);
        owed_rows = {owed_rows, row};
        idx = (idx + 1) % WINDOW_DEPTH;
      end
      held = 0;
    endfunction

    function void push_row(logic [PAY_W-1:0] payload);
      int unsigned span;
      span = keep_len + skip_newest;
      if (span > WINDOW_DEPTH) span = WINDOW_DEPTH;
      if (span == 0) begin
        held = 0;
        return;
      end
      ring[head[AW-1:0]] = payload;
      head = (head + 1) % WINDOW_DEPTH;
      if (held < WINDOW_DEPTH) held++;
      if (held > span) held = span;
    endfunction

    function void note_row_item(logic act, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
      if (act == ACT_FLUSH) begin
        close_group();
        group_open = 0;
      end else begin
        if (by_key && group_open && key != group_key) close_group();
        push_row(payload);
        group_key = key;
        group_open = 1;
      end
    endfunction

    function void check_kept_row(logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload,
                                 logic last);
      kept_row_t want;
      if (owed_rows.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected row: expected none, actual key %h payload %h last %b",
                   $time, key, payload, last);
        return;
      end
      want = owed_rows[0];
      owed_rows.delete(0);
      if (key !== want.key) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t out_key mismatch: expected %h actual %h", $time, want.key, key);
      end
      if (payload !== want.payload) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t out_payload mismatch: expected %h actual %h",
                   $time, want.payload, payload);
      end
      if (last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t out_last mismatch: expected %b actual %b", $time, want.last, last);
      end
    endfunction

    function int unsigned pending();
      return owed_rows.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata;   // row_key[31:0], row_payload[95:32]
  logic               s_axis_tuser;   // action
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [DATA_W-1:0]  m_axis_tdata;   // out_key[31:0], out_payload[95:32]
  logic               m_axis_tlast;   // out_last
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tail_scoreboard sb = new();

  int unsigned      snd_idle_pct;
  int unsigned      rcv_stall_pct;
  logic             hold_req;
  logic [KEY_W-1:0] next_key;
  int unsigned      cycles;

  last_n_per_sorted_group dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Offer one item, with an occasional gap first; returns at the accepting edge
  task automatic send_item(logic act, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {payload, key};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_row_item(act, key, payload);
  endtask

  // Setup then access phase, then the bus goes idle
  task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned len, int unsigned off, bit keys);
    write_reg(REG_KEEP_LEN, len);
    write_reg(REG_SKIP_LEN, off);
    write_reg(REG_KEYS_USED, 32'(keys));
  endtask

  // Stop offering, let every owed row come out, then let a pending store finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly sorted groups with random content, some flushes and stray keys
  task automatic run_random(int unsigned n);
    int unsigned left;
    int unsigned size;
    int unsigned r;
    left = n;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_item(ACT_FLUSH, $urandom, {$urandom, $urandom});
        left--;
      end else if (r < 14) begin
        send_item(ACT_ROW, $urandom, {$urandom, $urandom});
        left--;
      end else begin
        size = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        if (size > left) size = left;
        next_key = ($urandom_range(9) == 0) ? $urandom : next_key + $urandom_range(1, 1000);
        repeat (size) send_item(ACT_ROW, next_key, {$urandom, $urandom});
        left -= size;
      end
    end
  endtask

  // Receiver: checks rows, stalls at random, holds off once on request
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    hold_left = 0;
    hold_taken = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_kept_row(m_axis_tdata[KEY_W-1:0], m_axis_tdata[DATA_W-1:KEY_W],
                          m_axis_tlast);
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned      ph_len[6];
    int unsigned      ph_off[6];
    bit               ph_keys[6];
    int unsigned      ph_items[6];
    logic [KEY_W-1:0] k;

    ph_len   = '{32, 0, 32, 2, 4, 1};
    ph_off   = '{0, 0, 32, 3, 1, 32};
    ph_keys  = '{1, 1, 1, 1, 0, 1};
    ph_items = '{60, 30, 50, 60, 50, 30};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_ROW;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    hold_req      <= 1'b0;
    next_key = $urandom;
    snd_idle_pct = 26;
    rcv_stall_pct = 54;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: one row kept per group
    send_item(ACT_FLUSH, $urandom, {$urandom, $urandom});   // flush with nothing held
    send_item(ACT_ROW, '0, '0);
    send_item(ACT_ROW, '0, '1);
    send_item(ACT_ROW, '1, 64'h5555_5555_5555_5555);        // key change closes key 0
    send_item(ACT_ROW, '1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(ACT_FLUSH, '1, '1);
    send_item(ACT_FLUSH, '0, '0);
    send_item(ACT_ROW, 32'h8000_0000, 64'h8000_0000_0000_0001);
    send_item(ACT_ROW, 32'h7FFF_FFFF, {$urandom, $urandom});
    settle();

    // Unlisted address, then a window with an offset
    write_reg(REG_SPARE, 32'h3F);
    set_config(3, 1, 1);
    repeat (5) send_item(ACT_ROW, 32'd5, {$urandom, $urandom});
    send_item(ACT_ROW, 32'd6, {$urandom, $urandom});         // offset covers this group
    repeat (2) send_item(ACT_ROW, 32'd7, {$urandom, $urandom});
    send_item(ACT_FLUSH, $urandom, {$urandom, $urandom});
    send_item(ACT_ROW, 32'd8, {$urandom, $urandom});
    settle();
    set_config(3, 1, 0);                                     // one group across keys
    for (int unsigned i = 0; i < 4; i++) begin
      k = $urandom;
      send_item(ACT_ROW, k, {$urandom, $urandom});
    end
    send_item(ACT_FLUSH, $urandom, {$urandom, $urandom});

    // Random phases; idling pattern changes every three phases
    for (int unsigned p = 0; p < 9; p++) begin
      if (p == 3) begin
        snd_idle_pct = 54;
        rcv_stall_pct = 26;
      end else if (p == 6) begin
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
      end
      settle();
      if (p < 6)
        set_config(ph_len[p], ph_off[p], ph_keys[p]);
      else
        set_config($urandom_range(0, 32), $urandom_range(0, 32), $urandom_range(0, 9) != 0);
      if (p == 0) hold_req <= 1'b1;
      run_random((p < 6) ? ph_items[p] : 50);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
